// ===== hw/rtl/lbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// shared widths, operation codes and the job record passed from the front
// end to the byte emitter of the lsb-first bit packer
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int CODE_W        = 64;
  localparam int LEN_W         = 7;
  localparam int BYTE_W        = 8;
  localparam int FILL_W        = 3;
  localparam int PEND_W        = 7;
  localparam int ACC_W         = CODE_W + PEND_W;
  localparam int MAX_CODE_BITS = 64;
  localparam int MAX_BYTES     = CODE_W / BYTE_W;
  localparam int COUNT_W       = $clog2(MAX_BYTES + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // bytes to emit, oldest in the low byte, and how many of them
  typedef struct packed {
    logic [CODE_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lbp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_if
// valid/ready channels of the bit packer: code items in, bytes out
// ----------------------------------------------------------------------------
interface lbp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [lbp_pkg::CODE_W-1:0]   code;
  logic [lbp_pkg::LEN_W-1:0]    code_len;

  modport source (output valid, operation, code, code_len, input ready);
  modport sink   (input valid, operation, code, code_len, output ready);
endinterface

interface lbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbp_pkg::BYTE_W-1:0]   byte_out;
  logic                         last_byte;

  modport source (output valid, byte_out, last_byte, input ready);
  modport sink   (input valid, byte_out, last_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lsb_first_bit_packer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_unit
// packs variable-length codes into a byte stream, least significant bit first
// ----------------------------------------------------------------------------
// A write transaction appends the low code_len bits (saturated at 64) of code
// above up to seven pending bits and produces every byte that completes,
// oldest first, with last_byte set on the final byte of that transaction; a
// flush transaction produces the pending bits as one zero-padded byte when any
// are pending and clears them. The front end takes one transaction per cycle
// while its two-entry job queue has room; the byte emitter sends one byte per
// cycle while the output is ready, so a transaction that completes n bytes
// holds the single output byte lane for all n of them, and that lane sets the
// sustained rate. The first byte of a transaction passes through the job queue
// and the current-job register before it reaches the output register.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  lbp_in_if.sink     code_ch,
  lbp_out_if.source  byte_ch
);

  // job handoff between front end and emitter
  lbp_pkg::job_t wr_job;
  lbp_pkg::job_t rd_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  // merge codes with pending bits, one transaction per cycle while the queue has room
  lbp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (code_ch),
    .job   (wr_job),
    .push  (push),
    .full  (full)
  );

  // lets the front end run ahead while bytes drain
  lbp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  // one byte per cycle into the output register while the output is ready
  lbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd_job (rd_job),
    .empty  (empty),
    .pop    (pop),
    .bytes  (byte_ch)
  );

  // front end never writes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job pushed into full queue");

  // emitter never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("job popped from empty queue");

  // a taken byte that is not the last of its transaction is followed at once
  a_job_contiguous: assert property (@(posedge clk) disable iff (rst)
    (byte_ch.valid && byte_ch.ready && !byte_ch.last_byte) |=> byte_ch.valid)
    else $error("gap inside a transaction's bytes");

endmodule
`default_nettype wire

// ===== hw/rtl/lbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_front
// accepts code items, merges them with the pending bits and hands the
// completed bytes to the queue as one job
// ----------------------------------------------------------------------------
module lbp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  lbp_in_if.sink             items,
  output lbp_pkg::job_t      job,
  output logic               push,
  input  wire logic          full
);

  logic [lbp_pkg::PEND_W-1:0] pending_bits, pending_bits_next;
  logic [lbp_pkg::FILL_W-1:0] fill_count, fill_count_next;

  logic [lbp_pkg::LEN_W-1:0]  len_sat;
  logic [lbp_pkg::CODE_W-1:0] code_mask;
  logic [lbp_pkg::ACC_W-1:0]  acc;
  logic [lbp_pkg::LEN_W-1:0]  total;
  logic [lbp_pkg::COUNT_W-1:0] nbytes;
  logic [lbp_pkg::FILL_W-1:0] rest;
  logic [lbp_pkg::ACC_W-1:0]  acc_rest;
  logic                       accept;

  assign items.ready = !full;
  assign accept      = items.valid && !full;

  always_comb begin
    len_sat = (items.code_len > lbp_pkg::LEN_W'(lbp_pkg::MAX_CODE_BITS))
              ? lbp_pkg::LEN_W'(lbp_pkg::MAX_CODE_BITS) : items.code_len;
    // shift of all ones by 64 gives zero, so a full-length code keeps every bit
    code_mask = ~({lbp_pkg::CODE_W{1'b1}} << len_sat);
    acc = ({{lbp_pkg::PEND_W{1'b0}}, items.code & code_mask} << fill_count)
          | {{lbp_pkg::CODE_W{1'b0}}, pending_bits};
    total  = lbp_pkg::LEN_W'(fill_count) + len_sat;
    nbytes = lbp_pkg::COUNT_W'(total >> 3);
    rest   = total[lbp_pkg::FILL_W-1:0];
    acc_rest = acc >> {nbytes, 3'b000};

    job       = '0;
    push      = 1'b0;
    pending_bits_next = pending_bits;
    fill_count_next   = fill_count;
    if (items.operation == lbp_pkg::OP_FLUSH) begin
      job.data  = {{(lbp_pkg::CODE_W - lbp_pkg::PEND_W){1'b0}}, pending_bits};
      job.count = lbp_pkg::COUNT_W'(1);
      push      = accept && (fill_count != '0);
      pending_bits_next = '0;
      fill_count_next   = '0;
    end else begin
      job.data  = acc[lbp_pkg::CODE_W-1:0];
      job.count = nbytes;
      push      = accept && (nbytes != '0);
      pending_bits_next = acc_rest[lbp_pkg::PEND_W-1:0]
                          & lbp_pkg::PEND_W'((8'd1 << rest) - 8'd1);
      fill_count_next   = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits <= '0;
      fill_count   <= '0;
    end else if (accept) begin
      pending_bits <= pending_bits_next;
      fill_count   <= fill_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lbp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_queue
// short job queue between the front end and the byte emitter
// ----------------------------------------------------------------------------
module lbp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lbp_pkg::job_t wr_job,
  input  wire logic          pop,
  output lbp_pkg::job_t      rd_job,
  output logic               full,
  output logic               empty
);

  lbp_pkg::job_t               entries [lbp_pkg::QUEUE_DEPTH];
  logic [lbp_pkg::QPTR_W-1:0]  wr_ptr;
  logic [lbp_pkg::QPTR_W-1:0]  rd_ptr;
  logic [lbp_pkg::QCNT_W-1:0]  used;

  assign full   = (used == lbp_pkg::QCNT_W'(lbp_pkg::QUEUE_DEPTH));
  assign empty  = (used == '0);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lbp_pkg::QPTR_W'(lbp_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lbp_pkg::QPTR_W'(lbp_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        used <= used + 1'b1;
      end else if (pop && !push) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_back
// takes jobs from the queue and sends their bytes one per cycle, while the
// output is ready, through a registered output stage
// ----------------------------------------------------------------------------
module lbp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lbp_pkg::job_t rd_job,
  input  wire logic          empty,
  output logic               pop,
  lbp_out_if.source          bytes
);

  logic [lbp_pkg::CODE_W-1:0]  cur_data;
  logic [lbp_pkg::COUNT_W-1:0] cur_left;
  logic                        out_valid;
  logic [lbp_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_last;
  logic                        advance;

  assign advance = !out_valid || bytes.ready;
  assign pop     = !empty && ((cur_left == '0)
                   || (advance && cur_left == lbp_pkg::COUNT_W'(1)));

  assign bytes.valid     = out_valid;
  assign bytes.byte_out  = out_byte;
  assign bytes.last_byte = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_left  <= '0;
    end else begin
      if (advance) begin
        out_valid <= (cur_left != '0);
      end
      // a new job replaces the one whose last byte goes out now, or fills an idle emitter
      if (pop) begin
        cur_data <= rd_job.data;
        cur_left <= rd_job.count;
      end else if (advance && cur_left != '0) begin
        cur_data <= cur_data >> lbp_pkg::BYTE_W;
        cur_left <= cur_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cur_left != '0) begin
      out_byte <= cur_data[lbp_pkg::BYTE_W-1:0];
      out_last <= (cur_left == lbp_pkg::COUNT_W'(1));
    end
  end

endmodule
`default_nettype wire

// ===== tb/lbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_checker
// watches both channels of the bit packer, predicts the byte stream from the
// accepted code transactions and compares every byte transaction in order
// ----------------------------------------------------------------------------
module lbp_checker (
  input  wire logic clk,
  input  wire logic rst,
  lbp_in_if         code_ch,
  lbp_out_if        byte_ch,
  output int        fail_count,
  output int        bytes_owed
);
  import lbp_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } out_byte_t;

  out_byte_t         owed_bytes[$];
  logic [PEND_W-1:0] held_bits;
  logic [FILL_W-1:0] held_count;

  // append one code transaction to the bit stream, queue the bytes it completes
  function automatic void pack_code(input logic op, input logic [CODE_W-1:0] code,
                                    input logic [LEN_W-1:0] len);
    logic [ACC_W-1:0]  acc;
    logic [CODE_W-1:0] used;
    int                nbits;
    int                total;
    int                nbytes;
    int                rest;
    out_byte_t         b;
    if (op == OP_FLUSH) begin
      if (held_count != '0) begin
        b.value = BYTE_W'(held_bits);
        b.last  = 1'b1;
        owed_bytes.push_back(b);
      end
      held_bits  = '0;
      held_count = '0;
    end else begin
      nbits  = (int'(len) > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(len);
      used   = (nbits >= CODE_W) ? code : code & ((64'd1 << nbits) - 64'd1);
      acc    = ({{PEND_W{1'b0}}, used} << held_count) | ACC_W'(held_bits);
      total  = int'(held_count) + nbits;
      nbytes = total / BYTE_W;
      rest   = total % BYTE_W;
      for (int k = 0; k < nbytes; k++) begin
        b.value = acc[BYTE_W*k +: BYTE_W];
        b.last  = (k == nbytes - 1);
        owed_bytes.push_back(b);
      end
      acc        = acc >> (BYTE_W * nbytes);
      held_bits  = acc[PEND_W-1:0] & PEND_W'((8'd1 << rest) - 8'd1);
      held_count = FILL_W'(rest);
    end
  endfunction

  always @(posedge clk) begin
    out_byte_t want;
    if (rst) begin
      owed_bytes.delete();
      held_bits  = '0;
      held_count = '0;
      fail_count = 0;
    end else begin
      if (code_ch.valid && code_ch.ready)
        pack_code(code_ch.operation, code_ch.code, code_ch.code_len);
      if (byte_ch.valid && byte_ch.ready) begin
        if (owed_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected byte: expected none, got %02h last %0b",
                   $time, byte_ch.byte_out, byte_ch.last_byte);
        end else begin
          want = owed_bytes.pop_front();
          if (byte_ch.byte_out !== want.value || byte_ch.last_byte !== want.last) begin
            fail_count++;
            $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                     $time, want.value, want.last, byte_ch.byte_out, byte_ch.last_byte);
          end
        end
      end
    end
    bytes_owed = owed_bytes.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives code transactions into the lsb-first bit packer with random gaps and
// output stalls; the checker beside the block predicts and compares the bytes
// ----------------------------------------------------------------------------
module tb_top;
  import lbp_pkg::*;

  localparam int RANDOM_ITEMS = 405;
  localparam int CALM_FROM    = 345;   // last stretch of the run has no idling
  localparam int FULL_BURST   = 12;    // full-length codes offered during the long hold
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // handshake with the receiver process: calm turns off idling, hold_output
  // asks for one long output stall
  bit   calm        = 1'b0;
  bit   hold_output = 1'b0;

  int   fail_count;
  int   bytes_owed;
  int   cycle_count = 0;

  always #4 clk = ~clk;

  lbp_in_if  code_ch ();
  lbp_out_if byte_ch ();

  lsb_first_bit_packer_unit uut (
    .clk     (clk),
    .rst     (rst),
    .code_ch (code_ch),
    .byte_ch (byte_ch)
  );

  lbp_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .code_ch    (code_ch),
    .byte_ch    (byte_ch),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  // run limit, generous against the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d bytes still owed", $time, bytes_owed);
      $display("== FAIL ==");
      $finish;
    end
  end

  // byte receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    int stall;
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        // long hold so the job queue fills and the block stalls its input
        hold_output = 1'b0;
        byte_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 8);
        byte_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  // offer one code transaction, maybe after a random idle burst, and wait
  // until the block takes it
  task automatic offer_item(input logic op, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      code_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    code_ch.valid     <= 1'b1;
    code_ch.operation <= op;
    code_ch.code      <= code;
    code_ch.code_len  <= len;
    @(posedge clk);
    while (!code_ch.ready) @(posedge clk);
  endtask

  initial begin
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              op;
    int                pick;

    code_ch.valid     = 1'b0;
    code_ch.operation = OP_WRITE;
    code_ch.code      = '0;
    code_ch.code_len  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    offer_item(OP_WRITE, '1, 7'd0);                     // zero-length code
    offer_item(OP_FLUSH, '1, 7'd127);                   // flush with nothing pending
    offer_item(OP_WRITE, '1, 7'd3);                     // bits above the length dropped
    offer_item(OP_FLUSH, '0, 7'd64);                    // partial byte, zero padded
    offer_item(OP_WRITE, 64'h0123_4567_89ab_cdef, 7'd64); // eight whole bytes
    offer_item(OP_WRITE, '0, 7'd64);
    offer_item(OP_WRITE, 64'h0000_0000_0000_0016, 7'd5);
    offer_item(OP_WRITE, '1, 7'd64);                    // 69 bits, five left over
    offer_item(OP_WRITE, 64'h0000_0000_0000_0002, 7'd2); // seven pending
    offer_item(OP_WRITE, 64'hf0e1_d2c3_b4a5_9687, 7'd64); // widest fill, 71 bits
    offer_item(OP_FLUSH, '0, 7'd0);
    offer_item(OP_WRITE, {$urandom, $urandom}, 7'd127); // saturated length
    offer_item(OP_WRITE, '1, 7'd65);
    offer_item(OP_WRITE, 64'haaaa_aaaa_aaaa_aaaa, 7'd100);
    offer_item(OP_WRITE, 64'hffff_ffff_ffff_ffa5, 7'd8);
    // single bits build up a byte one at a time
    for (int i = 0; i < 8; i++)
      offer_item(OP_WRITE, {63'h7fff_ffff_ffff_fffe >> i, i[0]}, 7'd1);
    offer_item(OP_WRITE, '1, 7'd1);
    offer_item(OP_FLUSH, {$urandom, $urandom}, 7'd33);

    // ---- random part ----
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 0)
        hold_output = 1'b1;
      if (i == CALM_FROM)
        calm = 1'b1;
      code = {$urandom, $urandom};
      op   = OP_WRITE;
      pick = $urandom_range(0, 99);
      if (i < FULL_BURST) begin
        // full codes while the output is held: the queue fills up
        len = 7'd64;
      end else if (pick < 12) begin
        op  = OP_FLUSH;
        len = LEN_W'($urandom_range(0, 127));
      end else if (pick < 22) begin
        len = LEN_W'($urandom_range(64, 127));
      end else if (pick < 45) begin
        len = LEN_W'($urandom_range(17, 63));
      end else begin
        len = LEN_W'($urandom_range(0, 16));
      end
      offer_item(op, code, len);
    end

    @(negedge clk);
    code_ch.valid <= 1'b0;

    // drain: every owed byte in, then a wait for anything stray
    while (bytes_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
